// File: hdl/daqfcu_pkg.sv
// daqfcu_pkg: shared types, codes and constants of the readout frame channel unpacker.
// Used by daqfcu_chan_find, daq_frame_channel_unpacker and tb; depends on nothing.

package daqfcu_pkg;

	// Result kinds
	localparam logic [2:0] KIND_DAQ      = 3'd0;
	localparam logic [2:0] KIND_CM       = 3'd1;
	localparam logic [2:0] KIND_ROC_HDR  = 3'd2;
	localparam logic [2:0] KIND_LINK_CRC = 3'd3;
	localparam logic [2:0] KIND_FPGA_CRC = 3'd4;
	localparam logic [2:0] KIND_VER_ERR  = 3'd5;
	localparam logic [2:0] KIND_OVERRUN  = 3'd6;

	// Frame layout
	localparam int          MAX_LINKS_DEF = 64;
	localparam int          MAP_BITS      = 40;
	localparam int          VERSION_LSB   = 28;
	localparam logic [3:0]  HDR_VERSION   = 4'd1;
	localparam logic [5:0]  CRC_CHANNEL   = 6'd39;
	localparam logic [5:0]  CM_CHAN_V2    = 6'd19;
	localparam logic [5:0]  CM_CHAN_DEF   = 6'd1;
	localparam logic [5:0]  NO_CHANNEL    = 6'd63;
	localparam logic [1:0]  ROC_VER_V2    = 2'd2;
	localparam logic [1:0]  ROC_VER_RESET = 2'd3;

	// Link lengths are stored four to a row, 6 bits each
	localparam int LEN_BITS  = 6;
	localparam int ROW_LINKS = 4;
	localparam int ROW_BITS  = LEN_BITS * ROW_LINKS;

	// Outcome of the readout map search for one channel beat
	typedef struct packed {
		logic       found;
		logic [5:0] chan;
		logic [2:0] kind;
	} chan_res_t;

endpackage

// File: hdl/daqfcu_ram.sv
// daqfcu_ram: generic single write port, single read port RAM with registered read.
// No dependencies.

module daqfcu_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read, held between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: hdl/daqfcu_chan_find.sv
// daqfcu_chan_find: finds the next set readout map bit after the last channel
// and classifies the channel. Depends on daqfcu_pkg.

module daqfcu_chan_find (
	input  logic [daqfcu_pkg::MAP_BITS-1:0] readout_map,
	input  logic [5:0]                      last_channel,
	input  logic [1:0]                      roc_rev,
	output daqfcu_pkg::chan_res_t           res
);

	logic [6:0]                      start;
	logic [daqfcu_pkg::MAP_BITS-1:0] masked;
	logic [5:0]                      cm_chan;

	// search starts just above the last channel, or at bit 0 for a fresh link
	assign start = (last_channel == daqfcu_pkg::NO_CHANNEL) ? 7'd0
		: ({1'b0, last_channel} + 7'd1);

	assign cm_chan = (roc_rev == daqfcu_pkg::ROC_VER_V2) ? daqfcu_pkg::CM_CHAN_V2
		: daqfcu_pkg::CM_CHAN_DEF;

	// drop bits below the start point
	always_comb begin
		for (int i = 0; i < daqfcu_pkg::MAP_BITS; i++) begin
			masked[i] = readout_map[i] && (7'(i) >= start);
		end
	end

	// lowest set bit wins
	always_comb begin
		res.found = 1'b0;
		res.chan  = 6'd0;
		for (int i = daqfcu_pkg::MAP_BITS - 1; i >= 0; i--) begin
			if (masked[i]) begin
				res.found = 1'b1;
				res.chan  = 6'(i);
			end
		end
		if (res.chan == 6'd0) begin
			res.kind = daqfcu_pkg::KIND_ROC_HDR;
		end else if (res.chan == cm_chan) begin
			res.kind = daqfcu_pkg::KIND_CM;
		end else if (res.chan == daqfcu_pkg::CRC_CHANNEL) begin
			res.kind = daqfcu_pkg::KIND_LINK_CRC;
		end else begin
			res.kind = daqfcu_pkg::KIND_DAQ;
		end
	end

endmodule

// File: hdl/daq_frame_channel_unpacker.sv
// daq_frame_channel_unpacker: top level, frame parser with input and result registers.
// Depends on daqfcu_pkg, daqfcu_ram and daqfcu_chan_find.
//
// Channel   Handshake                  Payload
// word      word_valid / word_stall    word
// result    result_valid / result_stall kind, fpga_id, roc_id, link_index,
//                                       channel_number, payload
// config    cfg_valid / cfg_ready      roc_rev
//
// One word per cycle while the result channel is not stalled; each word is held in the input
// register, and its result is then written to the result register.
// The link length RAM read is issued on the link header beat and used on the map beat.
// Reset (arst_n low) returns the parser to expecting a frame header; no clearing pass.
// A stalled, full result register holds the input register, which then raises word_stall.

module daq_frame_channel_unpacker #(
	parameter int MAX_LINKS = daqfcu_pkg::MAX_LINKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// word channel
	input  logic        word_valid,
	output logic        word_stall,
	input  logic [31:0] word,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  kind,
	output logic [7:0]  fpga_id,
	output logic [15:0] roc_id,
	output logic [5:0]  link_index,
	output logic [5:0]  channel_number,
	output logic [31:0] payload,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  roc_rev
);

	localparam int LEN_ROWS = (MAX_LINKS + daqfcu_pkg::ROW_LINKS - 1) / daqfcu_pkg::ROW_LINKS;
	localparam int ROW_AW   = (LEN_ROWS > 1) ? $clog2(LEN_ROWS) : 1;

	// parser phases
	localparam logic [2:0] PH_HDR     = 3'd0;
	localparam logic [2:0] PH_BUNCH   = 3'd1;
	localparam logic [2:0] PH_LENS    = 3'd2;
	localparam logic [2:0] PH_LINK_HI = 3'd3;
	localparam logic [2:0] PH_LINK_LO = 3'd4;
	localparam logic [2:0] PH_CHAN    = 3'd5;
	localparam logic [2:0] PH_FCRC    = 3'd6;

	logic [1:0]  roc_rev_q;

	logic        valid_s1;
	logic [31:0] word_s1;
	logic        proc_en;

	logic [2:0]  phase_q,     phase_d;
	logic [7:0]  fpga_q,      fpga_d;
	logic [5:0]  link_cnt_q,  link_cnt_d;
	logic [5:0]  cur_link_q,  cur_link_d;
	logic [5:0]  words_q,     words_d;
	logic [15:0] roc_q,       roc_d;
	logic [daqfcu_pkg::MAP_BITS-1:0] map_q, map_d;
	logic [5:0]  last_chan_q, last_chan_d;

	logic        res_valid_q;
	logic [2:0]  kind_q,  kind_d;
	logic [7:0]  fpga_id_q, fpga_id_d;
	logic [15:0] roc_id_q, roc_id_d;
	logic [5:0]  link_q,  link_d;
	logic [5:0]  chan_q,  chan_d;
	logic [31:0] payload_q;
	logic        emit;

	logic                           lens_wr;
	logic                           lens_rd;
	logic [ROW_AW-1:0]              lens_row;
	logic [daqfcu_pkg::ROW_BITS-1:0] lens_wdata;
	logic [daqfcu_pkg::ROW_BITS-1:0] lens_rdata;
	logic [5:0]                     cur_len;

	logic [5:0]  hdr_links;
	logic [5:0]  nl_link;
	logic [2:0]  nl_phase;
	logic [5:0]  nl_idx;
	logic [6:0]  lens_next;
	logic [5:0]  words_dec;

	daqfcu_pkg::chan_res_t chan_res;

	// configuration register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roc_rev_q <= daqfcu_pkg::ROC_VER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			roc_rev_q <= roc_rev;
		end
	end

	// input register; it advances unless a full result register is stalled
	assign proc_en    = valid_s1 && !(res_valid_q && result_stall);
	assign word_stall = valid_s1 && !proc_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!word_stall) begin
			valid_s1 <= word_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (word_valid && !word_stall) begin
			word_s1 <= word;
		end
	end

	// link length store, one row of four lengths per length beat
	assign lens_wr    = proc_en && (phase_q == PH_LENS);
	assign lens_rd    = proc_en && (phase_q == PH_LINK_HI);
	assign lens_row   = ROW_AW'(cur_link_q >> 2);
	assign lens_wdata = {word_s1[29:24], word_s1[21:16], word_s1[13:8], word_s1[5:0]};

	daqfcu_ram #(
		.WIDTH (daqfcu_pkg::ROW_BITS),
		.DEPTH (LEN_ROWS)
	) u_lens (
		.clk     (clk),
		.wr_en   (lens_wr),
		.wr_addr (lens_row),
		.wr_data (lens_wdata),
		.rd_en   (lens_rd),
		.rd_addr (lens_row),
		.rd_data (lens_rdata)
	);

	assign cur_len = lens_rdata[daqfcu_pkg::LEN_BITS * cur_link_q[1:0] +: daqfcu_pkg::LEN_BITS];

	// next set map bit and its kind
	daqfcu_chan_find u_find (
		.readout_map  (map_q),
		.last_channel (last_chan_q),
		.roc_rev      (roc_rev_q),
		.res          (chan_res)
	);

	// helpers: clamped link count, move to next link, next length row, beat count
	assign hdr_links = ({1'b0, word_s1[19:14]} > 7'(MAX_LINKS)) ? 6'(MAX_LINKS)
		: word_s1[19:14];
	assign nl_idx    = cur_link_q + 6'd1;
	assign nl_link   = (nl_idx >= link_cnt_q) ? 6'd0 : nl_idx;
	assign nl_phase  = (nl_idx >= link_cnt_q) ? PH_FCRC : PH_LINK_HI;
	assign lens_next = {1'b0, cur_link_q} + 7'd4;
	assign words_dec = words_q - 6'd1;

	// parser step for the word in the input register
	always_comb begin
		phase_d     = phase_q;
		fpga_d      = fpga_q;
		link_cnt_d  = link_cnt_q;
		cur_link_d  = cur_link_q;
		words_d     = words_q;
		roc_d       = roc_q;
		map_d       = map_q;
		last_chan_d = last_chan_q;
		emit        = 1'b0;
		kind_d      = daqfcu_pkg::KIND_DAQ;
		fpga_id_d   = 8'd0;
		roc_id_d    = 16'd0;
		link_d      = 6'd0;
		chan_d      = 6'd0;
		unique case (phase_q)
			PH_HDR: begin
				if (word_s1[daqfcu_pkg::VERSION_LSB +: 4] != daqfcu_pkg::HDR_VERSION) begin
					emit   = 1'b1;
					kind_d = daqfcu_pkg::KIND_VER_ERR;
				end else begin
					fpga_d     = word_s1[27:20];
					link_cnt_d = hdr_links;
					cur_link_d = 6'd0;
					phase_d    = PH_BUNCH;
				end
			end
			PH_BUNCH: begin
				cur_link_d = 6'd0;
				phase_d    = (link_cnt_q == 6'd0) ? PH_FCRC : PH_LENS;
			end
			PH_LENS: begin
				if (lens_next >= {1'b0, link_cnt_q}) begin
					cur_link_d = 6'd0;
					phase_d    = PH_LINK_HI;
				end else begin
					cur_link_d = lens_next[5:0];
				end
			end
			PH_LINK_HI: begin
				roc_d   = word_s1[29:14];
				map_d   = {word_s1[7:0], 32'd0};
				phase_d = PH_LINK_LO;
			end
			PH_LINK_LO: begin
				map_d       = {map_q[daqfcu_pkg::MAP_BITS-1:32], word_s1};
				last_chan_d = daqfcu_pkg::NO_CHANNEL;
				words_d     = (cur_len >= 6'd2) ? (cur_len - 6'd2) : 6'd0;
				if (words_d == 6'd0) begin
					cur_link_d = nl_link;
					phase_d    = nl_phase;
				end else begin
					phase_d = PH_CHAN;
				end
			end
			PH_CHAN: begin
				emit      = 1'b1;
				fpga_id_d = fpga_q;
				roc_id_d  = roc_q;
				link_d    = cur_link_q;
				if (!chan_res.found) begin
					kind_d  = daqfcu_pkg::KIND_OVERRUN;
					phase_d = PH_HDR;
				end else begin
					kind_d      = chan_res.kind;
					chan_d      = chan_res.chan;
					last_chan_d = chan_res.chan;
					words_d     = words_dec;
					if (words_dec == 6'd0) begin
						cur_link_d = nl_link;
						phase_d    = nl_phase;
					end
				end
			end
			PH_FCRC: begin
				emit      = 1'b1;
				kind_d    = daqfcu_pkg::KIND_FPGA_CRC;
				fpga_id_d = fpga_q;
				phase_d   = PH_HDR;
			end
			default: begin
				phase_d = PH_HDR;
			end
		endcase
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR;
			fpga_q      <= 8'd0;
			link_cnt_q  <= 6'd0;
			cur_link_q  <= 6'd0;
			words_q     <= 6'd0;
			roc_q       <= 16'd0;
			map_q       <= '0;
			last_chan_q <= daqfcu_pkg::NO_CHANNEL;
		end else if (proc_en) begin
			phase_q     <= phase_d;
			fpga_q      <= fpga_d;
			link_cnt_q  <= link_cnt_d;
			cur_link_q  <= cur_link_d;
			words_q     <= words_d;
			roc_q       <= roc_d;
			map_q       <= map_d;
			last_chan_q <= last_chan_d;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (proc_en) begin
			res_valid_q <= emit;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (proc_en && emit) begin
			kind_q    <= kind_d;
			fpga_id_q <= fpga_id_d;
			roc_id_q  <= roc_id_d;
			link_q    <= link_d;
			chan_q    <= chan_d;
			payload_q <= word_s1;
		end
	end

	assign result_valid   = res_valid_q;
	assign kind           = kind_q;
	assign fpga_id        = fpga_id_q;
	assign roc_id         = roc_id_q;
	assign link_index     = link_q;
	assign channel_number = chan_q;
	assign payload        = payload_q;

	// checks on the parser
	a_chan_words_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CHAN) |-> (words_q != 6'd0))
		else $error("channel phase entered with no beats left");

	a_link_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LINK_HI || phase_q == PH_LINK_LO || phase_q == PH_CHAN)
		|-> (cur_link_q < link_cnt_q))
		else $error("current link beyond link count");

	a_ver_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind == daqfcu_pkg::KIND_VER_ERR)
		|-> (fpga_id == 8'd0 && roc_id == 16'd0 && link_index == 6'd0
			&& channel_number == 6'd0))
		else $error("version error result carries ids");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(proc_en))
		else $error("result appeared without a processed word");

	a_chan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (channel_number <= daqfcu_pkg::CRC_CHANNEL))
		else $error("channel number beyond map");

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for daq_frame_channel_unpacker, frame words in, channel beats out.
// Depends on daqfcu_pkg and the unpacker RTL; a built-in frame parser model predicts each beat.

module tb;
	import daqfcu_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int LONG_HOLD   = 300;

	typedef enum logic [2:0] {
		P_HDR, P_BUNCH, P_LENS, P_LINK_HI, P_LINK_LO, P_CHAN, P_FCRC
	} parse_phase_e;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  fpga;
		logic [15:0] roc;
		logic [5:0]  link;
		logic [5:0]  chan;
		logic [31:0] data;
	} unpacked_t;

	logic        clk;
	logic        arst_n;
	logic        word_valid;
	logic        word_stall;
	logic [31:0] word;
	logic        result_valid;
	logic        result_stall;
	logic [2:0]  kind;
	logic [7:0]  fpga_id;
	logic [15:0] roc_id;
	logic [5:0]  link_index;
	logic [5:0]  channel_number;
	logic [31:0] payload;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  roc_rev;

	daq_frame_channel_unpacker u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.word_valid     (word_valid),
		.word_stall     (word_stall),
		.word           (word),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.kind           (kind),
		.fpga_id        (fpga_id),
		.roc_id         (roc_id),
		.link_index     (link_index),
		.channel_number (channel_number),
		.payload        (payload),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.roc_rev        (roc_rev)
	);

	// Parser model state
	parse_phase_e fp_ph;
	logic [7:0]   fp_fpga;
	int           fp_nlinks;
	logic [5:0]   fp_len [64];
	int           fp_link;
	int           fp_left;
	logic [15:0]  fp_roc;
	logic [39:0]  fp_map;
	int           fp_last;
	logic [1:0]   fp_ver;

	unpacked_t    unpacked_q [$];

	// Frame under construction
	logic [5:0]   fr_len [64];
	logic [39:0]  fr_map [64];
	logic [15:0]  fr_roc [64];

	int err_cnt;
	int n_sent;
	int cycle_cnt;
	int word_gap_odds;
	int rcv_stall_odds;
	bit long_hold;

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	function automatic void push_unpacked(logic [2:0] k, logic [7:0] f, logic [15:0] r,
			logic [5:0] l, logic [5:0] c, logic [31:0] d);
		unpacked_q.push_back({k, f, r, l, c, d});
	endfunction

	function automatic void advance_link();
		fp_link = (fp_link + 1) & 63;
		if (fp_link >= fp_nlinks) begin
			fp_link = 0;
			fp_ph   = P_FCRC;
		end else begin
			fp_ph = P_LINK_HI;
		end
	endfunction

	// Frame parser model: one word in, zero or one expected beat out
	function automatic void unpack_word(logic [31:0] w);
		int         c;
		int         idx;
		int         n;
		logic [5:0] cm;
		logic [2:0] k;
		case (fp_ph)
			P_HDR: begin
				if (w[31:28] != HDR_VERSION) begin
					push_unpacked(KIND_VER_ERR, 8'd0, 16'd0, 6'd0, 6'd0, w);
				end else begin
					fp_fpga   = w[27:20];
					n         = w[19:14];
					fp_nlinks = (n > MAX_LINKS_DEF) ? MAX_LINKS_DEF : n;
					fp_link   = 0;
					fp_ph     = P_BUNCH;
				end
			end
			P_BUNCH: begin
				fp_link = 0;
				fp_ph   = (fp_nlinks == 0) ? P_FCRC : P_LENS;
			end
			P_LENS: begin
				for (int i = 0; i < ROW_LINKS; i++) begin
					idx = fp_link + i;
					if (idx < fp_nlinks)
						fp_len[idx] = w[8*i +: LEN_BITS];
				end
				if (fp_link + ROW_LINKS >= fp_nlinks) begin
					fp_link = 0;
					fp_ph   = P_LINK_HI;
				end else begin
					fp_link = (fp_link + ROW_LINKS) & 63;
				end
			end
			P_LINK_HI: begin
				fp_roc = w[29:14];
				fp_map = {w[7:0], 32'd0};
				fp_ph  = P_LINK_LO;
			end
			P_LINK_LO: begin
				n            = fp_len[fp_link];
				fp_map[31:0] = w;
				fp_last      = NO_CHANNEL;
				fp_left      = (n >= 2) ? n - 2 : 0;
				if (fp_left == 0)
					advance_link();
				else
					fp_ph = P_CHAN;
			end
			P_CHAN: begin
				c  = (fp_last == NO_CHANNEL) ? 0 : fp_last + 1;
				cm = (fp_ver == ROC_VER_V2) ? CM_CHAN_V2 : CM_CHAN_DEF;
				while (c < MAP_BITS && !fp_map[c])
					c++;
				if (c >= MAP_BITS) begin
					push_unpacked(KIND_OVERRUN, fp_fpga, fp_roc, 6'(fp_link), 6'd0, w);
					fp_ph = P_HDR;
				end else begin
					fp_last = c;
					if (c == 0)
						k = KIND_ROC_HDR;
					else if (c == cm)
						k = KIND_CM;
					else if (c == CRC_CHANNEL)
						k = KIND_LINK_CRC;
					else
						k = KIND_DAQ;
					push_unpacked(k, fp_fpga, fp_roc, 6'(fp_link), 6'(c), w);
					fp_left = (fp_left - 1) & 63;
					if (fp_left == 0)
						advance_link();
				end
			end
			P_FCRC: begin
				push_unpacked(KIND_FPGA_CRC, fp_fpga, 16'd0, 6'd0, 6'd0, w);
				fp_ph = P_HDR;
			end
			default: fp_ph = P_HDR;
		endcase
	endfunction

	// Result receiver: random stall bursts, and one long hold on request
	initial begin
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				result_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				result_stall <= 1'b0;
				long_hold = 1'b0;
			end else if (rcv_stall_odds != 0 && $urandom_range(1, rcv_stall_odds) == 1) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// Result checker; fields shown as kind/fpga/roc/link/chan/data
	always @(posedge clk) begin : chk
		unpacked_t got;
		unpacked_t want;
		if (arst_n && result_valid && !result_stall) begin
			got = {kind, fpga_id, roc_id, link_index, channel_number, payload};
			if (unpacked_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 50)
					$display("%0t: unexpected beat, expected none, actual kind=%0d data=%h",
						$time, kind, payload);
			end else begin
				want = unpacked_q.pop_front();
				if (got !== want) begin
					err_cnt++;
					if (err_cnt <= 50)
						$display(
						"%0t: mismatch, expected %0d/%h/%h/%0d/%0d/%h, actual %0d/%h/%h/%0d/%0d/%h",
							$time, want.kind, want.fpga, want.roc, want.link,
							want.chan, want.data, got.kind, got.fpga, got.roc, got.link,
							got.chan, got.data);
				end
			end
		end
	end

	// One word beat, with an optional random gap before it
	task automatic send_word(input logic [31:0] w);
		if (word_gap_odds != 0 && $urandom_range(1, word_gap_odds) == 1) begin
			word_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		unpack_word(w);
		word_valid <= 1'b1;
		word       <= w;
		@(posedge clk);
		while (word_stall)
			@(posedge clk);
		n_sent++;
	endtask

	// Sender stops; wait for all beats, then let in-flight words settle
	task automatic wait_results_drained();
		word_valid <= 1'b0;
		do
			@(posedge clk);
		while (unpacked_q.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_roc_rev(input logic [1:0] v);
		wait_results_drained();
		cfg_valid <= 1'b1;
		roc_rev   <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		fp_ver = v;
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [39:0] pick_map();
		logic [63:0] r;
		logic [63:0] s;
		r = {$urandom(), $urandom()};
		s = {$urandom(), $urandom()};
		case ($urandom_range(0, 7))
			0:       return '1;
			1:       return '0;
			2:       return (r[39:0] & s[39:0]) | 40'h80_0008_0003;
			3:       return r[39:0] & s[39:0];
			default: return r[39:0];
		endcase
	endfunction

	// Whole frame from fr_len / fr_map / fr_roc; stops early after a map overrun
	task automatic send_frame(input logic [7:0] fpga, input int nl);
		logic [31:0] w;
		int          nw;
		bit          aborted;
		aborted = 1'b0;
		while (fp_ph != P_HDR)
			send_word($urandom());
		w = $urandom();
		w[31:28] = HDR_VERSION;
		w[27:20] = fpga;
		w[19:14] = 6'(nl);
		send_word(w);
		send_word($urandom());
		for (int i = 0; i < nl; i += ROW_LINKS) begin
			w = $urandom();
			for (int j = 0; j < ROW_LINKS; j++)
				if (i + j < nl)
					w[8*j +: LEN_BITS] = fr_len[i+j];
			send_word(w);
		end
		for (int i = 0; i < nl && !aborted; i++) begin
			w = $urandom();
			w[29:14] = fr_roc[i];
			w[7:0]   = fr_map[i][39:32];
			send_word(w);
			send_word(fr_map[i][31:0]);
			nw = (fr_len[i] >= 2) ? fr_len[i] - 2 : 0;
			for (int k = 0; k < nw && !aborted; k++) begin
				send_word(pick_word());
				aborted = (fp_ph == P_HDR);
			end
		end
		if (!aborted)
			send_word(pick_word());
	endtask

	// Mostly well-formed frames; a few with odd lengths that overrun the map
	task automatic send_random_frame();
		int nl;
		int n_set;
		nl = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 63) : $urandom_range(0, 4);
		for (int i = 0; i < nl; i++) begin
			fr_map[i] = pick_map();
			fr_roc[i] = $urandom();
			n_set     = $countones(fr_map[i]);
			if (nl > 5)
				fr_len[i] = $urandom_range(0, 3);
			else
				case ($urandom_range(0, 9))
					0:       fr_len[i] = $urandom_range(0, 63);
					1:       fr_len[i] = $urandom_range(0, 1);
					default: fr_len[i] = 6'(2 + $urandom_range(0, n_set));
				endcase
		end
		send_frame($urandom(), nl);
	endtask

	// Stray words, some with a valid version so the parser wanders off
	task automatic send_noise();
		logic [31:0] w;
		repeat ($urandom_range(1, 4)) begin
			w = $urandom();
			if ($urandom_range(0, 1))
				w[31:28] = HDR_VERSION;
			send_word(w);
		end
	endtask

	task automatic run_random(input int count, input bit with_idle);
		int stop_at;
		stop_at = n_sent + count;
		while (n_sent < stop_at) begin
			if (with_idle) begin
				word_gap_odds  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 10);
				rcv_stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 10);
			end else begin
				word_gap_odds  = 0;
				rcv_stall_odds = 0;
			end
			if ($urandom_range(0, 9) == 0)
				send_noise();
			else
				send_random_frame();
		end
	endtask

	// Version errors, zero links, short links, extremes, CRC and overrun
	task automatic test_directed_frames();
		word_gap_odds  = 4;
		rcv_stall_odds = 4;
		send_word(32'hFFFF_FFFF);
		send_word(32'h0000_0000);
		send_frame(8'hFF, 0);
		fr_len[0] = 6'd1;
		fr_map[0] = pick_map();
		fr_roc[0] = 16'h0000;
		fr_len[1] = 6'd6;
		fr_map[1] = 40'h00_0008_0007;
		fr_roc[1] = 16'hFFFF;
		send_frame(8'h00, 2);
		fr_len[0] = 6'd63;
		fr_map[0] = 40'h80_0000_0000;
		fr_roc[0] = $urandom();
		send_frame(8'h5A, 1);
	endtask

	// Common-mode channel moves to 19 with ROC version 2
	task automatic test_common_mode_select();
		write_roc_rev(ROC_VER_V2);
		fr_len[0] = 6'd6;
		fr_map[0] = 40'h00_0008_0007;
		fr_roc[0] = $urandom();
		send_frame($urandom(), 1);
	endtask

	// Receiver holds off while the sender keeps offering full-map links
	task automatic test_result_backpressure();
		word_gap_odds  = 0;
		rcv_stall_odds = 0;
		wait_results_drained();
		fr_len[0] = 6'd42;
		fr_map[0] = '1;
		fr_roc[0] = $urandom();
		long_hold = 1'b1;
		send_frame($urandom(), 1);
		send_frame($urandom(), 1);
	endtask

	// Sender pauses mid-stream until every beat is out
	task automatic test_pause_for_drain();
		send_random_frame();
		wait_results_drained();
		send_random_frame();
	endtask

	initial begin
		word_valid <= 1'b0;
		word       <= 32'd0;
		cfg_valid  <= 1'b0;
		roc_rev    <= ROC_VER_RESET;
		arst_n     <= 1'b0;
		err_cnt        = 0;
		n_sent         = 0;
		word_gap_odds  = 0;
		rcv_stall_odds = 0;
		long_hold      = 1'b0;
		// model state after reset
		fp_ph     = P_HDR;
		fp_fpga   = 8'd0;
		fp_nlinks = 0;
		fp_link   = 0;
		fp_left   = 0;
		fp_roc    = 16'd0;
		fp_map    = 40'd0;
		fp_last   = NO_CHANNEL;
		fp_ver    = ROC_VER_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		test_common_mode_select();
		run_random(700, 1'b1);
		test_result_backpressure();
		write_roc_rev(ROC_VER_RESET);
		run_random(600, 1'b1);
		test_pause_for_drain();
		write_roc_rev(ROC_VER_V2);
		run_random(400, 1'b1);
		write_roc_rev(ROC_VER_RESET);
		run_random(300, 1'b0);

		wait_results_drained();
		repeat (10) @(posedge clk);
		if (err_cnt == 0 && unpacked_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: filelist.f
hdl/daqfcu_pkg.sv
hdl/daqfcu_ram.sv
hdl/daqfcu_chan_find.sv
hdl/daq_frame_channel_unpacker.sv
tb/tb.sv
